/* sv/eidt_pkg.sv */
// Shared types and constants for the epoch to ISO date-time text block.
// Used by the front pipeline, the digit queue, the character serializer and the top level.
`timescale 1ns / 1ps

package eidt_pkg;

    // Characters per formatted string: YYYY-MM-DDTHH:MM:SS
    localparam int NUM_CHARS = 19;
    localparam int CHAR_IDX_W = $clog2(NUM_CHARS);
    localparam logic [CHAR_IDX_W-1:0] LAST_CHAR_IDX = CHAR_IDX_W'(NUM_CHARS - 1);

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // ASCII codes
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_DASH  = 8'h2D;
    localparam logic [7:0] CHR_T     = 8'h54;
    localparam logic [7:0] CHR_COLON = 8'h3A;

    // All decimal digits of one date-time, tens digit first in each pair
    typedef struct packed {
        logic [3:0] cent_hi;
        logic [3:0] cent_lo;
        logic [3:0] yy_hi;
        logic [3:0] yy_lo;
        logic [3:0] mon_hi;
        logic [3:0] mon_lo;
        logic [3:0] dom_hi;
        logic [3:0] dom_lo;
        logic [3:0] hr_hi;
        logic [3:0] hr_lo;
        logic [3:0] min_hi;
        logic [3:0] min_lo;
        logic [3:0] sec_hi;
        logic [3:0] sec_lo;
    } t_digits;

    // Queue fill status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* sv/eidt_front.sv */
// Front pipeline: accepts epoch seconds and converts them to date-time digits.
// Depends on eidt_pkg; feeds eidt_queue.
`timescale 1ns / 1ps

module eidt_front
    import eidt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [30:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output t_digits     o_digits
);

    localparam int NSTG = 11;

    // Reciprocal multipliers: floor(n / d) = (n * m) >> k over each value range
    localparam logic [24:0] DAY_RECIP  = 25'd25451658;  // / 675, approximate, corrected
    localparam int          DAY_SHIFT  = 34;
    localparam logic [9:0]  DAY_DIV    = 10'd675;       // 86400 >> 7
    localparam logic [16:0] SECS_DAY   = 17'd86400;
    localparam logic [17:0] YEAR_RECIP = 18'd183735;    // / 1461
    localparam int          YEAR_SHIFT = 28;
    localparam logic [10:0] DAYS_QUAD  = 11'd1461;
    localparam logic [17:0] HOUR_RECIP = 18'd149131;    // / 3600
    localparam int          HOUR_SHIFT = 29;
    localparam logic [11:0] SECS_HOUR  = 12'd3600;
    localparam logic [12:0] MIN_RECIP  = 13'd4370;      // / 60
    localparam int          MIN_SHIFT  = 18;
    localparam logic [5:0]  SECS_MIN   = 6'd60;
    localparam logic [8:0]  FEB_END    = 9'd58;
    localparam logic [13:0] MON_RECIP  = 14'd11429;     // / 367
    localparam int          MON_SHIFT  = 22;
    localparam logic [8:0]  MON_LEN    = 9'd367;
    localparam logic [12:0] DIV12_RECIP = 13'd5462;     // / 12
    localparam int          DIV12_SHIFT = 16;
    localparam logic [6:0]  YOFF_2000  = 7'd30;         // first year offset of the 2000s

    // Split a value below 100 into tens and units
    function automatic logic [7:0] two_digit(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [6:0]  units;
        p     = 15'(v) * 15'(205);
        tens  = p[14:11];
        units = v - 7'(7'(tens) * 7'd10);
        return {tens, units[3:0]};
    endfunction

    logic [NSTG-1:0] r_vld;
    logic            adv;

    logic [30:0] r_secs1, r_secs2, r_secs3;
    logic [14:0] r_q2, r_q3;
    logic [24:0] r_p3;
    logic [14:0] r_day4, r_day5;
    logic [16:0] r_tod4, r_tod5;
    logic [6:0]  r_yoff5, r_yoff6, r_yoff7, r_yoff8, r_yoff9, r_yoff10;
    logic [4:0]  r_hh5, r_hh6, r_hh7, r_hh8, r_hh9, r_hh10;
    logic [8:0]  r_doy6;
    logic [11:0] r_remh6, r_remh7;
    logic [8:0]  r_adj7, r_adj8, r_adj9;
    logic [5:0]  r_mm7, r_mm8, r_mm9, r_mm10;
    logic [3:0]  r_mon8, r_mon9, r_mon10;
    logic [5:0]  r_ss8, r_ss9, r_ss10;
    logic [11:0] r_t9;
    logic [4:0]  r_dom10;
    t_digits     r_dig11;

    logic [48:0] s2_prod;
    logic [31:0] s4_rem;
    logic        s4_corr;
    logic [16:0] s5_n;
    logic [34:0] s5_yprod, s5_hprod;
    logic [16:0] s6_yd, s6_hs;
    logic [14:0] s6_doy;
    logic [16:0] s6_remh;
    logic        s7_leap;
    logic [8:0]  s7_thr;
    logic [24:0] s7_mprod;
    logic [12:0] s8_n;
    logic [26:0] s8_mprod;
    logic [11:0] s8_ss;
    logic [24:0] s10_prod;
    logic [8:0]  s10_dom;
    logic [6:0]  s11_yy;
    logic [7:0]  s11_yyd, s11_mond, s11_domd, s11_hrd, s11_mind, s11_secd;

    // Move the whole pipeline when the last stage is empty or the queue takes it
    assign adv     = !r_vld[NSTG-1] || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_vld[NSTG-1];
    assign o_digits = r_dig11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // Day count estimate, low by at most one
    assign s2_prod = 49'(r_secs1[30:7]) * 49'(DAY_RECIP);

    // Remainder and correction of the day count
    assign s4_rem  = {1'b0, r_secs3} - {r_p3, 7'b0};
    assign s4_corr = s4_rem[17:0] >= 18'(SECS_DAY);

    // Year offset and hour
    assign s5_n     = {r_day4, 2'b10};
    assign s5_yprod = 35'(s5_n) * 35'(YEAR_RECIP);
    assign s5_hprod = 35'(r_tod4) * 35'(HOUR_RECIP);

    // Day of the year and seconds of the hour
    assign s6_yd   = 17'(r_yoff5) * 17'(DAYS_QUAD) + 17'd1;
    assign s6_doy  = r_day5 - 15'(s6_yd[16:2]);
    assign s6_hs   = 17'(r_hh5) * 17'(SECS_HOUR);
    assign s6_remh = r_tod5 - s6_hs;

    // Skip past February; minutes
    assign s7_leap  = (r_yoff6[1:0] == 2'd2);
    assign s7_thr   = FEB_END + 9'(s7_leap);
    assign s7_mprod = 25'(r_remh6) * 25'(MIN_RECIP);

    // Month and seconds
    assign s8_n     = 13'(r_adj7) * 13'd12 + 13'd6;
    assign s8_mprod = 27'(s8_n) * 27'(MON_RECIP);
    assign s8_ss    = r_remh7 - 12'(12'(r_mm7) * 12'(SECS_MIN));

    // Day of the month
    assign s10_prod = 25'(r_t9) * 25'(DIV12_RECIP);
    assign s10_dom  = r_adj9 + 9'd1 - s10_prod[DIV12_SHIFT +: 9];

    // Two-digit year within the century
    assign s11_yy   = (r_yoff10 < YOFF_2000) ? r_yoff10 + 7'd70 : r_yoff10 - YOFF_2000;
    assign s11_yyd  = two_digit(s11_yy);
    assign s11_mond = two_digit(7'(r_mon10) + 7'd1);
    assign s11_domd = two_digit(7'(r_dom10));
    assign s11_hrd  = two_digit(7'(r_hh10));
    assign s11_mind = two_digit(7'(r_mm10));
    assign s11_secd = two_digit(7'(r_ss10));

    // Payload stages advance together
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_secs1 <= i_epoch_seconds;

            r_secs2 <= r_secs1;
            r_q2    <= s2_prod[DAY_SHIFT +: 15];

            r_secs3 <= r_secs2;
            r_q3    <= r_q2;
            r_p3    <= 25'(r_q2) * 25'(DAY_DIV);

            r_day4  <= r_q3 + 15'(s4_corr);
            r_tod4  <= s4_corr ? 17'(s4_rem[17:0] - 18'(SECS_DAY)) : s4_rem[16:0];

            r_day5  <= r_day4;
            r_tod5  <= r_tod4;
            r_yoff5 <= s5_yprod[YEAR_SHIFT +: 7];
            r_hh5   <= s5_hprod[HOUR_SHIFT +: 5];

            r_doy6  <= s6_doy[8:0];
            r_remh6 <= s6_remh[11:0];
            r_yoff6 <= r_yoff5;
            r_hh6   <= r_hh5;

            if (r_doy6 > s7_thr) begin
                r_adj7 <= r_doy6 + (s7_leap ? 9'd1 : 9'd2);
            end else begin
                r_adj7 <= r_doy6;
            end
            r_mm7   <= s7_mprod[MIN_SHIFT +: 6];
            r_remh7 <= r_remh6;
            r_yoff7 <= r_yoff6;
            r_hh7   <= r_hh6;

            r_mon8  <= s8_mprod[MON_SHIFT +: 4];
            r_ss8   <= s8_ss[5:0];
            r_adj8  <= r_adj7;
            r_mm8   <= r_mm7;
            r_yoff8 <= r_yoff7;
            r_hh8   <= r_hh7;

            r_t9    <= 12'(r_mon8) * 12'(MON_LEN) + 12'd5;
            r_mon9  <= r_mon8;
            r_adj9  <= r_adj8;
            r_ss9   <= r_ss8;
            r_mm9   <= r_mm8;
            r_yoff9 <= r_yoff8;
            r_hh9   <= r_hh8;

            r_dom10  <= s10_dom[4:0];
            r_mon10  <= r_mon9;
            r_ss10   <= r_ss9;
            r_mm10   <= r_mm9;
            r_yoff10 <= r_yoff9;
            r_hh10   <= r_hh9;

            // Century is 19 before year offset 30, 20 from there on
            r_dig11.cent_hi <= (r_yoff10 < YOFF_2000) ? 4'd1 : 4'd2;
            r_dig11.cent_lo <= (r_yoff10 < YOFF_2000) ? 4'd9 : 4'd0;
            r_dig11.yy_hi   <= s11_yyd[7:4];
            r_dig11.yy_lo   <= s11_yyd[3:0];
            r_dig11.mon_hi  <= s11_mond[7:4];
            r_dig11.mon_lo  <= s11_mond[3:0];
            r_dig11.dom_hi  <= s11_domd[7:4];
            r_dig11.dom_lo  <= s11_domd[3:0];
            r_dig11.hr_hi   <= s11_hrd[7:4];
            r_dig11.hr_lo   <= s11_hrd[3:0];
            r_dig11.min_hi  <= s11_mind[7:4];
            r_dig11.min_lo  <= s11_mind[3:0];
            r_dig11.sec_hi  <= s11_secd[7:4];
            r_dig11.sec_lo  <= s11_secd[3:0];
        end
    end

endmodule

/* sv/eidt_queue.sv */
// Short shift queue of converted date-time digits between front and back.
// Depends on eidt_pkg.
`timescale 1ns / 1ps

module eidt_queue
    import eidt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_digits   i_data,
    input  logic      i_pop,
    output t_q_status o_stat,
    output t_digits   o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_digits         r_ent [DEPTH];
    logic [CW-1:0]   r_cnt;
    logic            push;
    logic            pop;
    logic [CW-1:0]   wr_cnt;
    logic [PW-1:0]   wr_idx;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign push   = i_valid && !o_stat.full;
    assign pop    = i_pop && !o_stat.empty;
    assign wr_cnt = pop ? r_cnt - CW'(1) : r_cnt;
    assign wr_idx = wr_cnt[PW-1:0];
    assign o_head = r_ent[0];

    // Track the fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CW'(push) - CW'(pop);
        end
    end

    // Shift toward the head on pop; write behind the last held transaction
    for (genvar g = 0; g < DEPTH; g++) begin : g_ent
        always_ff @(posedge i_clk) begin
            if (push && wr_idx == PW'(g)) begin
                r_ent[g] <= i_data;
            end else if (pop) begin
                if (g < DEPTH - 1) begin
                    r_ent[g] <= r_ent[(g < DEPTH - 1) ? g + 1 : g];
                end
            end
        end
    end

endmodule

/* sv/eidt_back.sv */
// Back end: serializes queued digits into 19 ASCII characters, one per cycle unless stalled or empty.
// Depends on eidt_pkg; reads the head of eidt_queue.
`timescale 1ns / 1ps

module eidt_back
    import eidt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_status i_q_stat,
    input  t_digits   i_head,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output logic [7:0] o_text_char,
    output logic      o_last_char
);

    // Pick the character at one position of YYYY-MM-DDTHH:MM:SS
    function automatic logic [7:0] pick_char(input t_digits d,
                                             input logic [CHAR_IDX_W-1:0] idx);
        logic [3:0] dg;
        logic       is_digit;
        logic [7:0] sep;
        dg       = 4'd0;
        is_digit = 1'b1;
        sep      = CHR_ZERO;
        unique case (idx)
            5'd0:  dg = d.cent_hi;
            5'd1:  dg = d.cent_lo;
            5'd2:  dg = d.yy_hi;
            5'd3:  dg = d.yy_lo;
            5'd4:  begin is_digit = 1'b0; sep = CHR_DASH; end
            5'd5:  dg = d.mon_hi;
            5'd6:  dg = d.mon_lo;
            5'd7:  begin is_digit = 1'b0; sep = CHR_DASH; end
            5'd8:  dg = d.dom_hi;
            5'd9:  dg = d.dom_lo;
            5'd10: begin is_digit = 1'b0; sep = CHR_T; end
            5'd11: dg = d.hr_hi;
            5'd12: dg = d.hr_lo;
            5'd13: begin is_digit = 1'b0; sep = CHR_COLON; end
            5'd14: dg = d.min_hi;
            5'd15: dg = d.min_lo;
            5'd16: begin is_digit = 1'b0; sep = CHR_COLON; end
            5'd17: dg = d.sec_hi;
            5'd18: dg = d.sec_lo;
            default: dg = 4'd0;
        endcase
        return is_digit ? CHR_ZERO + {4'b0, dg} : sep;
    endfunction

    logic [CHAR_IDX_W-1:0] r_idx;
    logic                  r_ovld;
    logic [7:0]            r_char;
    logic                  r_last;
    logic                  load;
    logic                  take;

    assign load  = !r_ovld || !i_stall;
    assign take  = load && !i_q_stat.empty;
    assign o_pop = take && (r_idx == LAST_CHAR_IDX);

    assign o_valid     = r_ovld;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

    // Advance the character position and the output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_ovld <= 1'b0;
        end else if (load) begin
            r_ovld <= !i_q_stat.empty;
            if (take) begin
                r_idx <= (r_idx == LAST_CHAR_IDX) ? '0 : r_idx + CHAR_IDX_W'(1);
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_char <= pick_char(i_head, r_idx);
            r_last <= (r_idx == LAST_CHAR_IDX);
        end
    end

endmodule

/* sv/epoch_to_iso_datetime_text.sv */
// Epoch seconds to ISO 8601 text YYYY-MM-DDTHH:MM:SS, one character per output transaction.
// Each input passes the front stages and the queue, then the output register emits its characters.
// Input rate is bounded by the output register, one character per cycle unless stalled.
// An 11-stage front and a queue (default depth 2) let new inputs enter while text drains.
// Reset: synchronous, active low; clears valid bits, queue count and character position.
`timescale 1ns / 1ps

module epoch_to_iso_datetime_text
    import eidt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [30:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_text_char,
    output logic        o_last_char
);

    logic      f_valid;
    t_digits   f_digits;
    t_q_status q_stat;
    t_digits   q_head;
    logic      q_pop;

    // Convert seconds to digits
    eidt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_epoch_seconds (i_epoch_seconds),
        .o_valid         (f_valid),
        .i_stall         (q_stat.full),
        .o_digits        (f_digits)
    );

    // Buffer converted transactions
    eidt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_data  (f_digits),
        .i_pop   (q_pop),
        .o_stat  (q_stat),
        .o_head  (q_head)
    );

    // Emit characters
    eidt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

`ifndef SYNTH
    // Queue cannot be full and empty at once
    a_q_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty together");

    // Popping an entry puts its final character on the output
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (o_valid && o_last_char))
        else $error("pop without final character");

    // Input stalls only when converted data waits on a full queue
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (f_valid && q_stat.full))
        else $error("front stalled without back pressure");

    // Never pop an empty queue
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

/* sim/tb_epoch_to_iso_datetime_text.sv */
// Self-checking testbench for epoch_to_iso_datetime_text: directed table, then random epochs.
// Depends on eidt_pkg and the epoch_to_iso_datetime_text RTL; checks every text character.
`timescale 1ns / 1ps

module tb_epoch_to_iso_datetime_text;
    import eidt_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 40;
    localparam int DIR_ROWS     = 22;

    typedef struct {
        logic [30:0] secs;
        string       text;   // empty where the predictor supplies the text
    } dir_row_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_beat_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC
    } rx_mode_e;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [30:0] i_epoch_seconds = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_text_char;
    logic        o_last_char;

    // Extremes, leap and non-leap February, year and day boundaries, bit patterns
    dir_row_t dir_table [DIR_ROWS] = '{
        '{31'd0,          "1970-01-01T00:00:00"},
        '{31'h7FFFFFFF,   "2038-01-19T03:14:07"},
        '{31'd946684799,  "1999-12-31T23:59:59"},
        '{31'd1,          ""},
        '{31'd59,         ""},
        '{31'd60,         ""},
        '{31'd3599,       ""},
        '{31'd3600,       ""},
        '{31'd86399,      ""},
        '{31'd86400,      ""},
        '{31'd5097599,    ""},
        '{31'd5097600,    ""},
        '{31'd68169600,   ""},
        '{31'd68255999,   ""},
        '{31'd94694399,   ""},
        '{31'd946684800,  ""},
        '{31'd951782400,  ""},
        '{31'd951868799,  ""},
        '{31'd951868800,  ""},
        '{31'd2145916799, ""},
        '{31'h55555555,   ""},
        '{31'h2AAAAAAA,   ""}
    };

    logic [30:0] epoch_list[$];
    string       typed_text[$];
    text_beat_t  text_due[$];
    text_beat_t  due_beat;

    int unsigned epochs_sent = 0;
    int unsigned chars_checked = 0;
    int unsigned rx_stall_cycles = 0;
    int unsigned fail_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned mode_left = 0;
    int unsigned rx_period = 8;
    int unsigned rx_duty = 1;
    int unsigned rx_phase = 0;
    rx_mode_e    rx_mode = RX_OPEN;

    epoch_to_iso_datetime_text dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_epoch_seconds(i_epoch_seconds),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_text_char    (o_text_char),
        .o_last_char    (o_last_char)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Two decimal digits, tens digit taken modulo 10
    function automatic string digit_pair(int unsigned v);
        return $sformatf("%c%c", CHR_ZERO + 8'((v / 10) % 10), CHR_ZERO + 8'(v % 10));
    endfunction

    // Calendar text for a count of seconds since 1970, four-year leap rule
    function automatic string iso_text(logic [30:0] secs);
        int unsigned day, tod, yoff, year, mon, dom;
        bit          leap;
        day  = secs / 86400;
        tod  = secs % 86400;
        yoff = (day * 4 + 2) / 1461;
        year = 1970 + yoff;
        leap = (year % 4) == 0;
        day  = day - (yoff * 1461 + 1) / 4;
        if (day > (leap ? 59 : 58)) begin
            day = day + (leap ? 1 : 2);
        end
        mon = (day * 12 + 6) / 367;
        dom = day + 1 - (mon * 367 + 5) / 12;
        return $sformatf("%s%s-%s-%sT%s:%s:%s",
                         digit_pair(year / 100), digit_pair(year % 100),
                         digit_pair(mon + 1), digit_pair(dom), digit_pair(tod / 3600),
                         digit_pair((tod / 60) % 60), digit_pair(tod % 60));
    endfunction

    // Mostly uniform, the rest near day ends and around February or the end of a random year
    function automatic logic [30:0] random_epoch();
        longint unsigned day, secs;
        case ($urandom_range(0, 9))
            6, 7: begin
                day  = $urandom_range(0, 24855);
                secs = day * 86400 + ($urandom_range(0, 1) ? 86399 : 0);
            end
            8, 9: begin
                day  = ($urandom_range(0, 67) * 1461 + 1) / 4;
                day  = day + ($urandom_range(0, 3) == 0 ? $urandom_range(364, 365)
                                                        : $urandom_range(57, 61));
                secs = day * 86400 + $urandom_range(0, 86399);
            end
            default: begin
                secs = 31'($urandom());
            end
        endcase
        if (secs > 64'h7FFFFFFF) begin
            secs = 64'h7FFFFFFF;
        end
        return 31'(secs);
    endfunction

    // Sender: bursts of random length, random gaps; hold the payload while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                string txt;
                txt = (typed_text[epochs_sent] != "") ? typed_text[epochs_sent]
                                                      : iso_text(i_epoch_seconds);
                for (int k = 0; k < NUM_CHARS; k++) begin
                    text_due.push_back('{ch: txt[k], last: (k == NUM_CHARS - 1)});
                end
                epochs_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (epochs_sent < epoch_list.size()) begin
                    i_valid <= 1'b1;
                    i_epoch_seconds <= epoch_list[epochs_sent];
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: open, random or periodic stall, switching mode at random times
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_e'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 150);
                rx_period = $urandom_range(2, 40);
                rx_duty   = $urandom_range(1, rx_period - 1);
                rx_phase  = 0;
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_RANDOM:   i_stall <= ($urandom_range(0, 9) < 3);
                RX_PERIODIC: i_stall <= (rx_phase < rx_duty);
                default:     i_stall <= 1'b0;
            endcase
            rx_phase = (rx_phase + 1) % rx_period;
        end
    end

    // Compare each accepted character with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (i_stall) begin
                rx_stall_cycles++;
            end else if (text_due.size() == 0) begin
                $error("unexpected character: text_char %h last_char %b",
                       o_text_char, o_last_char);
                fail_count++;
            end else begin
                due_beat = text_due.pop_front();
                if (o_text_char !== due_beat.ch) begin
                    $error("text_char mismatch: expected %h, actual %h", due_beat.ch, o_text_char);
                    fail_count++;
                end
                if (o_last_char !== due_beat.last) begin
                    $error("last_char mismatch: expected %b, actual %b",
                           due_beat.last, o_last_char);
                    fail_count++;
                end
                chars_checked++;
            end
        end
    end

    // Watchdog: end the run after too many cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Build the stimulus, release reset, wait for the text to drain, report
    initial begin
        foreach (dir_table[r]) begin
            epoch_list.push_back(dir_table[r].secs);
            typed_text.push_back(dir_table[r].text);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            epoch_list.push_back(random_epoch());
            typed_text.push_back("");
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (epochs_sent < epoch_list.size() || text_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("converted %0d epoch values (%0d from the directed table), checked %0d chars",
                 epochs_sent, DIR_ROWS, chars_checked);
        $display("receiver held off output for %0d cycles, %0d mismatches",
                 rx_stall_cycles, fail_count);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
